// ----- rtl/ilie_pkg.sv -----
package ilie_pkg;

  // Field widths of the request and result words
  localparam int CMD_W  = 4;
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  // Default geometry of the list
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  // Width of the index bounds broadcast along the row; covers the largest depth plus one
  localparam int BOUND_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 4'd0,
    CMD_WRITE  = 4'd1,
    CMD_APPEND = 4'd2,
    CMD_REMOVE = 4'd3,
    CMD_INSERT = 4'd4,
    CMD_ERASE  = 4'd5,
    CMD_CLEAR  = 4'd6,
    CMD_RESIZE = 4'd7,
    CMD_FILL   = 4'd8
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What the cells of the row do in one cycle
  typedef enum logic [1:0] {
    ROW_HOLD   = 2'd0,
    ROW_LOAD   = 2'd1,
    ROW_INSERT = 2'd2,
    ROW_ERASE  = 2'd3
  } row_op_t;

  typedef struct packed {
    row_op_t              op;
    logic [BOUND_W-1:0]   lo;
    logic [BOUND_W-1:0]   hi;
  } row_ctl_t;

endpackage

// ----- rtl/ilie_if.sv -----
interface ilie_in_if;
  logic                              valid;
  logic                              ready;
  logic [ilie_pkg::CMD_W-1:0]        cmd;
  logic [ilie_pkg::POS_W-1:0]        position;
  logic signed [ilie_pkg::WORD_W-1:0] word_in;

  modport source (output valid, cmd, position, word_in, input ready);
  modport sink   (input valid, cmd, position, word_in, output ready);
endinterface

interface ilie_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ilie_pkg::WORD_W-1:0] word_out;
  logic [ilie_pkg::STAT_W-1:0]       status;
  logic [ilie_pkg::FILL_W-1:0]       fill_count;
  logic                              is_empty;

  modport source (output valid, word_out, status, fill_count, is_empty, input ready);
  modport sink   (input valid, word_out, status, fill_count, is_empty, output ready);
endinterface

// ----- rtl/ilie_cell.sv -----
module ilie_cell #(
  parameter int WORD_BITS = ilie_pkg::WORD_BITS_DEF,
  parameter int INDEX     = 0
) (
  input  logic                     clk,
  input  ilie_pkg::row_ctl_t       row_ctl,
  input  logic [WORD_BITS-1:0]     load_word,
  input  logic [WORD_BITS-1:0]     lo_word,
  input  logic [WORD_BITS-1:0]     hi_word,
  output logic [WORD_BITS-1:0]     word_q
);
  import ilie_pkg::*;

  localparam logic [BOUND_W-1:0] IDX = BOUND_W'(INDEX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;
  logic                 at_lo;
  logic                 in_rng;
  logic                 above_lo;

  assign at_lo    = (IDX == row_ctl.lo);
  assign above_lo = (IDX > row_ctl.lo) && (IDX < row_ctl.hi);
  assign in_rng   = (IDX >= row_ctl.lo) && (IDX < row_ctl.hi);

  always_comb begin
    word_nxt = word_r;
    unique case (row_ctl.op)
      ROW_HOLD:   word_nxt = word_r;
      ROW_LOAD:   if (in_rng) word_nxt = load_word;
      ROW_INSERT: begin
        // take the new word at the slot, move the neighbor below up above it
        if (at_lo) word_nxt = load_word;
        else if (above_lo) word_nxt = lo_word;
      end
      ROW_ERASE:  if (in_rng) word_nxt = hi_word;
      default:    word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

// ----- rtl/ilie_ctrl.sv -----
module ilie_ctrl #(
  parameter int DEPTH = ilie_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ilie_in_if.sink                      in_ch,
  ilie_out_if.source                   out_ch,
  input  logic [ilie_pkg::WORD_W-1:0]  rd_word,
  output ilie_pkg::row_ctl_t           row_ctl
);
  import ilie_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [BOUND_W-1:0] DEPTH_B = BOUND_W'(DEPTH);

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] word_r;
  status_t           status_r;
  logic [FILL_W-1:0] fill_r;
  logic              empty_r;

  logic              acc;
  logic              rd_ok;
  status_t           st;
  row_ctl_t          ctl;
  logic [BOUND_W-1:0] pos_b;
  logic [BOUND_W-1:0] cnt_b;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign pos_b       = BOUND_W'(in_ch.position);
  assign cnt_b       = BOUND_W'(count_r);

  always_comb begin
    st        = ST_OK;
    rd_ok     = 1'b0;
    count_nxt = count_r;
    ctl.op    = ROW_HOLD;
    ctl.lo    = '0;
    ctl.hi    = '0;
    unique case (in_ch.cmd)
      CMD_READ: begin
        if (pos_b < cnt_b) rd_ok = 1'b1;
        else st = ST_RANGE;
      end
      CMD_WRITE: begin
        if (pos_b < cnt_b) begin
          ctl.op = ROW_LOAD;
          ctl.lo = pos_b;
          ctl.hi = pos_b + 1'b1;
        end else begin
          st = ST_RANGE;
        end
      end
      CMD_APPEND: begin
        if (cnt_b < DEPTH_B) begin
          ctl.op    = ROW_LOAD;
          ctl.lo    = cnt_b;
          ctl.hi    = cnt_b + 1'b1;
          count_nxt = CW'(count_r + 1'b1);
        end else begin
          st = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (count_r == '0) st = ST_EMPTY;
        else count_nxt = CW'(count_r - 1'b1);
      end
      CMD_INSERT: begin
        priority if (pos_b > cnt_b) begin
          st = ST_RANGE;
        end else if (cnt_b >= DEPTH_B) begin
          st = ST_FULL;
        end else begin
          ctl.op    = ROW_INSERT;
          ctl.lo    = pos_b;
          ctl.hi    = cnt_b + 1'b1;
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      CMD_ERASE: begin
        if (pos_b >= cnt_b) begin
          st = ST_RANGE;
        end else begin
          ctl.op    = ROW_ERASE;
          ctl.lo    = pos_b;
          ctl.hi    = cnt_b - 1'b1;
          count_nxt = CW'(count_r - 1'b1);
        end
      end
      CMD_CLEAR: count_nxt = '0;
      CMD_RESIZE: begin
        if (pos_b > DEPTH_B) begin
          st = ST_FULL;
        end else begin
          ctl.op    = ROW_LOAD;
          ctl.lo    = cnt_b;
          ctl.hi    = pos_b;
          count_nxt = CW'(pos_b);
        end
      end
      CMD_FILL: begin
        if (pos_b > DEPTH_B) begin
          st = ST_FULL;
        end else begin
          ctl.op    = ROW_LOAD;
          ctl.lo    = '0;
          ctl.hi    = pos_b;
          count_nxt = CW'(pos_b);
        end
      end
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    row_ctl = ctl;
    if (!acc) row_ctl.op = ROW_HOLD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      word_r   <= rd_ok ? rd_word : '0;
      status_r <= st;
      fill_r   <= FILL_W'(count_nxt);
      empty_r  <= (count_nxt == '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.word_out   = word_r;
  assign out_ch.status     = status_r;
  assign out_ch.fill_count = fill_r;
  assign out_ch.is_empty   = empty_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    BOUND_W'(count_r) <= DEPTH_B)
    else $error("fill count above depth");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.cmd == CMD_CLEAR) |=> (count_r == '0 && out_ch.is_empty))
    else $error("clear left entries");

  a_read_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.cmd == CMD_READ) |=> (count_r == $past(count_r)))
    else $error("read changed fill count");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_EMPTY) |-> (count_r == '0 && empty_r))
    else $error("empty status on non-empty list");
`endif

endmodule

// ----- rtl/indexed_list_insert_erase_unit.sv -----
// Result: the result word of a request is registered at the edge that accepts it and valid after that edge.
// Throughput: one request per cycle while results are taken; every cell of the row moves its word
//   in that same cycle, so insert and erase shift the whole list at once.
// A result word the drain side has not taken stalls the input; taking it frees the slot that cycle.
// Reset (rst_n, synchronous, active low) empties the list and drops any pending result;
//   stored words are not cleared and are never visible beyond the fill count.
module indexed_list_insert_erase_unit #(
  parameter int DEPTH     = ilie_pkg::DEPTH_DEF,
  parameter int WORD_BITS = ilie_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ilie_in_if.sink     in_ch,
  ilie_out_if.source  out_ch
);
  import ilie_pkg::*;

  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  row_ctl_t             row_ctl;
  logic [WORD_BITS-1:0] cell_q [DEPTH];
  logic [WORD_BITS-1:0] store_word;
  logic signed [63:0]   in_ext;
  logic signed [63:0]   rd_ext;
  logic [BOUND_W-1:0]   pos_b;
  logic [IDXW-1:0]      rd_idx;
  logic [WORD_W-1:0]    rd_word;

  // Sign-extend the incoming word, then cut it to the stored width
  assign in_ext     = 64'(in_ch.word_in);
  assign store_word = in_ext[WORD_BITS-1:0];

  // Read select; an index past the row is out of range and its word is dropped by control
  assign pos_b   = BOUND_W'(in_ch.position);
  assign rd_idx  = pos_b[IDXW-1:0];
  assign rd_ext  = 64'(signed'(cell_q[rd_idx]));
  assign rd_word = rd_ext[WORD_W-1:0];

  // Decode, fill count and result register
  ilie_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .rd_word (rd_word),
    .row_ctl (row_ctl)
  );

  // Row of storage cells; each sees its neighbors below and above for shifts
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] lo_w;
    logic [WORD_BITS-1:0] hi_w;

    if (i == 0) begin : g_first
      assign lo_w = '0;
    end else begin : g_lo
      assign lo_w = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign hi_w = '0;
    end else begin : g_hi
      assign hi_w = cell_q[i+1];
    end

    ilie_cell #(
      .WORD_BITS (WORD_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .row_ctl   (row_ctl),
      .load_word (store_word),
      .lo_word   (lo_w),
      .hi_word   (hi_w),
      .word_q    (cell_q[i])
    );
  end

endmodule
